// ===== rtl/srd_pkg.sv =====
// shared types, codes and constants of the sensor response deframer
package srd_pkg;

    // default sizes, handed to the top level parameters
    localparam int MAX_PACKET_DEF = 96;
    localparam int MAX_DATA_DEF   = 64;

    // field widths
    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 7;
    localparam int IDX_W  = 6;
    localparam int STS_W  = 2;
    localparam int LEN_W  = 16;

    // frame constants
    localparam logic [BYTE_W-1:0] HDR0      = 8'hef;
    localparam logic [BYTE_W-1:0] HDR1      = 8'h01;
    localparam logic [BYTE_W-1:0] KIND_ACK  = 8'h07;
    localparam logic [BYTE_W-1:0] KIND_DATA = 8'h02;
    localparam int                HEAD_LEN  = 9;
    localparam logic [BYTE_W-1:0] CONFIRM_NONE = 8'hff;

    // header byte positions
    localparam int POS_FIRST_ADDR = 2;
    localparam int POS_KIND       = 6;
    localparam int POS_LEN_HI     = 7;
    localparam int POS_LEN_LO     = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

    // status codes
    localparam logic [STS_W-1:0] ST_BUSY = 2'd0;
    localparam logic [STS_W-1:0] ST_OK   = 2'd1;
    localparam logic [STS_W-1:0] ST_FAIL = 2'd2;
    localparam logic [STS_W-1:0] ST_IDLE = 2'd3;

    // transaction phase
    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_HUNT = 6'b000010,
        PH_HEAD = 6'b000100,
        PH_PAY  = 6'b001000,
        PH_OK   = 6'b010000,
        PH_FAIL = 6'b100000
    } t_phase;

    // one input request
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] rx_byte;
        logic [CNT_W-1:0]  want_bytes;
    } t_item;

    // one result
    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [BYTE_W-1:0] confirm_code;
        logic              ack_seen;
        logic              data_valid;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  data_index;
        logic [CNT_W-1:0]  data_length;
    } t_result;

endpackage

// ===== rtl/srd_if.sv =====
// request and result channel interfaces of the sensor response deframer
interface srd_in_if import srd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] rx_byte;
    logic [CNT_W-1:0]  want_bytes;

    modport source(output valid, command, rx_byte, want_bytes, input ready);
    modport sink(input valid, command, rx_byte, want_bytes, output ready);
endinterface

interface srd_out_if import srd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [STS_W-1:0]  status;
    logic [BYTE_W-1:0] confirm_code;
    logic              ack_seen;
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  data_index;
    logic [CNT_W-1:0]  data_length;

    modport source(output valid, status, confirm_code, ack_seen, data_valid, data_byte,
                   data_index, data_length, input ready);
    modport sink(input valid, status, confirm_code, ack_seen, data_valid, data_byte,
                 data_index, data_length, output ready);
endinterface

// ===== rtl/sensor_response_deframer_top.sv =====
// top level of the sensor response deframer: request stage, core and result register
//
// Takes one request per clock while the output keeps up: a start (with the wanted data
// size), a received UART byte or a timeout event, and returns exactly one result per
// request. Each request is held in an input register, passes the per-byte header, counter
// and compare logic of the core and lands in the result register, so the sustained rate
// is one request per cycle while results are taken. The input register can still take a
// request while a result waits on a stalled output, and the block stops taking new ones
// only when both registers are full. Data bytes are delivered as they arrive with their
// index; the data length counts them once their packet completes.
module sensor_response_deframer_top import srd_pkg::*; #(
    parameter int MAX_PACKET = MAX_PACKET_DEF,
    parameter int MAX_DATA   = MAX_DATA_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srd_in_if.sink    i_req,
    srd_out_if.source o_rsp
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    t_result step_result;
    logic    advance;

    // request moves into the core when the result register is free or being read
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_item.command    <= i_req.command;
            r_in_item.rx_byte    <= i_req.rx_byte;
            r_in_item.want_bytes <= i_req.want_bytes;
        end
    end

    srd_core #(
        .MAX_PACKET(MAX_PACKET),
        .MAX_DATA  (MAX_DATA)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in_item),
        .o_result(step_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.confirm_code = r_out.confirm_code;
    assign o_rsp.ack_seen     = r_out.ack_seen;
    assign o_rsp.data_valid   = r_out.data_valid;
    assign o_rsp.data_byte    = r_out.data_byte;
    assign o_rsp.data_index   = r_out.data_index;
    assign o_rsp.data_length  = r_out.data_length;

    // a data byte is never reported with an idle or failed transaction
    a_dv_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data_valid) |-> (o_rsp.status == ST_BUSY || o_rsp.status == ST_OK))
        else $error("data byte with idle or failed status");

    // a successful finish always follows an acknowledge
    a_ok_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_OK) |-> o_rsp.ack_seen)
        else $error("finished ok without acknowledge");

    // committed data never exceeds the data limit
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> ({1'b0, o_rsp.data_length} <= (CNT_W+1)'(MAX_DATA)))
        else $error("data length beyond limit");

    // a held request is not lost while the result side stalls
    a_hold_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("held request changed");

endmodule

// ===== rtl/srd_core.sv =====
// deframer state registers and the per-byte next-state and result logic
module srd_core import srd_pkg::*; #(
    parameter int MAX_PACKET = MAX_PACKET_DEF,
    parameter int MAX_DATA   = MAX_DATA_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    localparam int PW = $clog2(MAX_PACKET + 1);
    localparam int IW = ((PW > CNT_W) ? PW : CNT_W) + 1;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_prev, n_prev;
    logic [PW-1:0]     r_pos, n_pos;
    logic [BYTE_W-1:0] r_kind, n_kind;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_cap, n_cap;
    logic [CNT_W-1:0]  r_del, n_del;
    logic              r_ack, n_ack;
    logic [BYTE_W-1:0] r_conf, n_conf;

    // next state and result for the current request
    always_comb begin
        logic              working;
        logic              do_finish;
        logic [PW-1:0]     len_s;
        logic [PW-1:0]     off;
        logic [IW-1:0]     idx;
        logic              emit;
        logic [CNT_W-1:0]  room;
        logic [LEN_W-1:0]  add;
        logic [CNT_W-1:0]  add_c;
        logic [CNT_W:0]    want_c;
        logic              dv;
        logic [BYTE_W-1:0] db;
        logic [IDX_W-1:0]  di;

        n_phase   = r_phase;
        n_prev    = r_prev;
        n_pos     = r_pos;
        n_kind    = r_kind;
        n_len     = r_len;
        n_cap     = r_cap;
        n_del     = r_del;
        n_ack     = r_ack;
        n_conf    = r_conf;
        do_finish = 1'b0;
        len_s     = r_len[PW-1:0];
        off       = r_pos - PW'(HEAD_LEN);
        idx       = '0;
        emit      = 1'b0;
        room      = '0;
        add       = '0;
        add_c     = '0;
        want_c    = {1'b0, i_item.want_bytes};
        dv        = 1'b0;
        db        = '0;
        di        = '0;
        working   = (r_phase == PH_HUNT) || (r_phase == PH_HEAD) || (r_phase == PH_PAY);

        unique case (i_item.command)
            CMD_START: begin
                n_cap   = (want_c > (CNT_W+1)'(MAX_DATA)) ? CNT_W'(MAX_DATA)
                                                          : i_item.want_bytes;
                n_del   = '0;
                n_ack   = 1'b0;
                n_conf  = CONFIRM_NONE;
                n_kind  = '0;
                n_len   = '0;
                n_phase = PH_HUNT;
                n_prev  = '0;
                n_pos   = '0;
            end
            CMD_TIMEOUT: begin
                if (working) begin
                    n_phase = r_ack ? PH_OK : PH_FAIL;
                end
            end
            CMD_BYTE: begin
                if (r_phase == PH_HUNT) begin
                    // header hunt
                    if (r_prev == HDR0 && i_item.rx_byte == HDR1) begin
                        n_phase = PH_HEAD;
                        n_pos   = PW'(POS_FIRST_ADDR);
                    end
                    n_prev = i_item.rx_byte;
                end else if (r_phase == PH_HEAD) begin
                    // address, id and length bytes
                    if (r_pos == PW'(POS_KIND)) begin
                        n_kind = i_item.rx_byte;
                    end else if (r_pos == PW'(POS_LEN_HI)) begin
                        n_len = {i_item.rx_byte, 8'h00};
                    end else if (r_pos == PW'(POS_LEN_LO)) begin
                        n_len = {r_len[15:8], i_item.rx_byte};
                    end
                    if (r_pos == PW'(POS_LEN_LO)) begin
                        if ({1'b0, n_len} + (LEN_W+1)'(HEAD_LEN) > (LEN_W+1)'(MAX_PACKET)) begin
                            n_phase = PH_FAIL;
                        end else if (n_len == '0) begin
                            do_finish = 1'b1;
                        end else begin
                            n_phase = PH_PAY;
                            n_pos   = PW'(HEAD_LEN);
                        end
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end else if (r_phase == PH_PAY) begin
                    // payload byte, first one is the pending confirm
                    if (off == '0) begin
                        n_prev = i_item.rx_byte;
                    end
                    if (r_kind == KIND_ACK && len_s >= PW'(3) && off >= PW'(1)
                        && off <= len_s - PW'(3)) begin
                        idx  = IW'(r_del) + IW'(off) - IW'(1);
                        emit = 1'b1;
                    end else if (r_kind == KIND_DATA && r_cap != '0 && len_s > PW'(2)
                                 && off < len_s - PW'(2)) begin
                        idx  = IW'(r_del) + IW'(off);
                        emit = 1'b1;
                    end
                    if (emit && idx < IW'(r_cap)) begin
                        dv = 1'b1;
                        db = i_item.rx_byte;
                        di = idx[IDX_W-1:0];
                    end
                    n_pos = r_pos + 1'b1;
                    if ({1'b0, n_pos} >= (PW+1)'(HEAD_LEN) + {1'b0, len_s}) begin
                        do_finish = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        // packet end: commit data count and decide on finish
        if (do_finish) begin
            room    = (r_cap > r_del) ? r_cap - r_del : '0;
            n_phase = PH_HUNT;
            if (r_kind == KIND_ACK && n_len >= LEN_W'(3)) begin
                n_conf = n_prev;
                n_ack  = 1'b1;
                add    = n_len - LEN_W'(3);
                add_c  = (add > LEN_W'(room)) ? room : add[CNT_W-1:0];
                n_del  = r_del + add_c;
                if (n_conf != '0 || n_del >= r_cap) begin
                    n_phase = PH_OK;
                end
            end else if (r_kind == KIND_DATA && r_cap != '0) begin
                add    = (n_len > LEN_W'(2)) ? n_len - LEN_W'(2) : '0;
                add_c  = (add > LEN_W'(room)) ? room : add[CNT_W-1:0];
                n_del  = r_del + add_c;
                if (r_ack && n_del >= r_cap) begin
                    n_phase = PH_OK;
                end
            end
            if (n_phase == PH_HUNT) begin
                n_prev = '0;
                n_pos  = '0;
            end
        end

        // result fields
        unique case (n_phase)
            PH_IDLE: o_result.status = ST_IDLE;
            PH_OK:   o_result.status = ST_OK;
            PH_FAIL: o_result.status = ST_FAIL;
            default: o_result.status = ST_BUSY;
        endcase
        o_result.confirm_code = n_conf;
        o_result.ack_seen     = n_ack;
        o_result.data_valid   = dv;
        o_result.data_byte    = db;
        o_result.data_index   = di;
        o_result.data_length  = n_del;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_prev  <= '0;
            r_pos   <= '0;
            r_kind  <= '0;
            r_len   <= '0;
            r_cap   <= '0;
            r_del   <= '0;
            r_ack   <= 1'b0;
            r_conf  <= CONFIRM_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_pos   <= n_pos;
            r_kind  <= n_kind;
            r_len   <= n_len;
            r_cap   <= n_cap;
            r_del   <= n_del;
            r_ack   <= n_ack;
            r_conf  <= n_conf;
        end
    end

endmodule
